>>> src/trsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS record SNI parser package
// Shared request and result types and constants of the record parser.
// ----------------------------------------------------------------------------
package trsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic        name_last;
    logic        valid_res;
    logic [7:0]  rec_kind;
    logic [15:0] rec_ver;
    logic [15:0] rec_len;
    logic        hs_present;
    logic [7:0]  hs_kind;
    logic        ch_flag;
    logic        truncated;
    logic        sni_found;
  } out_res_t;

  localparam logic       KindName    = 1'b0;
  localparam logic       KindSummary = 1'b1;
  localparam logic [7:0] TypeMin     = 8'd20;
  localparam logic [7:0] TypeMax     = 8'd24;
  localparam logic [7:0] TypeHs      = 8'd22;
  localparam logic [7:0] VerMajor    = 8'h03;
  localparam logic [7:0] VerMinorMax = 8'h04;
  localparam logic [7:0] HsClientHi  = 8'd1;
  localparam logic [15:0] MaxLenReset = 16'd16384;

endpackage

>>> src/tls_record_sni_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS record SNI parser core
// Checks a TLS record header and extracts the ClientHello host name.
// ----------------------------------------------------------------------------
// One payload byte is taken per cycle and parsed in the same cycle; each byte
// gives at most a host name byte and, on the last byte, a summary. Results
// pass through a four-entry result queue, so a request is taken in every
// cycle while the queue has two free entries; the sustained rate is one byte
// per cycle when the consumer takes a result in every cycle. Host name bytes
// are tentative until the summary reports sni_found.
module tls_record_sni_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  trsp_pkg::in_req_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output trsp_pkg::out_res_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  typedef enum logic [4:0] {
    PH_HDR, PH_IGNORE, PH_HS, PH_FIXED, PH_SID_LEN, PH_SID, PH_CS_LEN, PH_CS,
    PH_CM_LEN, PH_CM, PH_EXTS_LEN, PH_EXT_HDR, PH_EXT_SKIP, PH_LIST_LEN,
    PH_NAME_HDR, PH_NAME_SKIP, PH_NAME
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] rem;
    logic [31:0] fv;
    logic [15:0] rec_left;
    logic [15:0] ext_left;
    logic [15:0] list_left;
    logic [7:0]  hs_type;
    logic        hdr_ok;
    logic        has_hs;
    logic        is_ch;
    logic        trunc;
    logic        sni;
  } pst_t;

  localparam pst_t PstReset = '{phase: PH_HDR, default: '0};

  function automatic pst_t start_fld(pst_t s, phase_e ph, logic [15:0] n);
    pst_t r;
    r = s;
    if (n > s.rec_left) begin
      r.trunc = 1'b1;
      r.phase = PH_IGNORE;
    end else begin
      r.phase = ph;
      r.rem   = n;
      r.fv    = '0;
    end
    return r;
  endfunction

  function automatic pst_t ext_loop(pst_t s);
    pst_t r;
    r = s;
    if (s.ext_left >= 16'd4) begin
      r.ext_left = s.ext_left - 16'd4;
      r = start_fld(r, PH_EXT_HDR, 16'd4);
    end else begin
      r.phase = PH_IGNORE;
    end
    return r;
  endfunction

  function automatic pst_t name_loop(pst_t s);
    pst_t r;
    r = s;
    if (s.list_left >= 16'd3) begin
      r.list_left = s.list_left - 16'd3;
      r = start_fld(r, PH_NAME_HDR, 16'd3);
    end else begin
      r.phase = PH_IGNORE;
    end
    return r;
  endfunction

  function automatic pst_t complete(pst_t s);
    pst_t r;
    logic [15:0] len;
    r = s;
    len = s.fv[15:0];
    case (s.phase)
      PH_HS: begin
        r.hs_type = s.fv[31:24];
        r.has_hs  = 1'b1;
        if (s.fv[31:24] != trsp_pkg::HsClientHi) begin
          r.phase = PH_IGNORE;
        end else begin
          r.is_ch = 1'b1;
          if (s.fv[23:0] > {8'd0, s.rec_left}) begin
            r.trunc = 1'b1;
            r.phase = PH_IGNORE;
          end else begin
            r = start_fld(r, PH_FIXED, 16'd34);
          end
        end
      end
      PH_FIXED:    r = start_fld(s, PH_SID_LEN, 16'd1);
      PH_SID_LEN:  r = start_fld(s, PH_SID, len);
      PH_SID:      r = start_fld(s, PH_CS_LEN, 16'd2);
      PH_CS_LEN:   r = start_fld(s, PH_CS, len);
      PH_CS:       r = start_fld(s, PH_CM_LEN, 16'd1);
      PH_CM_LEN:   r = start_fld(s, PH_CM, len);
      PH_CM:       r = start_fld(s, PH_EXTS_LEN, 16'd2);
      PH_EXTS_LEN: begin
        r.ext_left = len;
        r = ext_loop(r);
      end
      PH_EXT_HDR: begin
        if (len > s.ext_left) begin
          r.trunc = 1'b1;
          r.phase = PH_IGNORE;
        end else if (s.fv[31:16] == 16'd0) begin
          r = start_fld(s, PH_LIST_LEN, 16'd2);
        end else begin
          r.ext_left = s.ext_left - len;
          r = start_fld(r, PH_EXT_SKIP, len);
        end
      end
      PH_EXT_SKIP: r = ext_loop(s);
      PH_LIST_LEN: begin
        if (len > s.rec_left) begin
          r.phase = PH_IGNORE;
        end else begin
          r.list_left = len;
          r = name_loop(r);
        end
      end
      PH_NAME_HDR: begin
        if (len > s.list_left) begin
          r.phase = PH_IGNORE;
        end else if (s.fv[31:16] == 16'd0) begin
          r = start_fld(s, PH_NAME, len);
        end else begin
          r.list_left = s.list_left - len;
          r = start_fld(r, PH_NAME_SKIP, len);
        end
      end
      PH_NAME_SKIP: r = name_loop(s);
      PH_NAME: begin
        r.sni   = 1'b1;
        r.phase = PH_IGNORE;
      end
      default: r.phase = PH_IGNORE;
    endcase
    return r;
  endfunction

  // a finished field opens at most one empty field before a non-empty one
  function automatic pst_t settle(pst_t s);
    pst_t r;
    r = s;
    for (int i = 0; i < 2; i++) begin
      if (r.phase != PH_HDR && r.phase != PH_IGNORE && r.rem == 16'd0) begin
        r = complete(r);
      end
    end
    return r;
  endfunction

  pst_t                pst_q, pst_d, pst_w;
  logic [16:0]         cnt_q, cnt_d, cnt_w;
  logic [39:0]         hdr_q, hdr_d, hdr_w;
  logic [15:0]         max_len_q;
  trsp_pkg::out_res_t  fifo_q [4];
  logic [1:0]          wr_ptr_q, rd_ptr_q;
  logic [2:0]          cnt_fifo_q;
  logic                in_fire, out_fire, push_name, push_sum;
  trsp_pkg::out_res_t  res_name, res_sum;
  logic [7:0]          b;
  logic [15:0]         hlen;
  logic                hdr_good, rec_valid;
  logic [2:0]          n_push;

  assign b        = in_data_i.data_byte;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign hlen     = hdr_w[15:0];

  always_comb begin
    pst_w     = pst_q;
    hdr_w     = hdr_q;
    push_name = 1'b0;
    res_name  = '0;
    hdr_good  = 1'b0;
    if (pst_q.phase == PH_HDR) begin
      hdr_w = {hdr_q[31:0], b};
      if (cnt_q == 17'd4) begin
        hdr_good = hdr_w[39:32] >= trsp_pkg::TypeMin && hdr_w[39:32] <= trsp_pkg::TypeMax
                && hdr_w[31:24] == trsp_pkg::VerMajor
                && hdr_w[23:16] <= trsp_pkg::VerMinorMax
                && hlen != 16'd0 && hlen <= max_len_q;
        pst_w.phase = PH_IGNORE;
        if (hdr_good) begin
          pst_w.hdr_ok   = 1'b1;
          pst_w.rec_left = hlen;
          if (hdr_w[39:32] == trsp_pkg::TypeHs && hlen >= 16'd4) begin
            pst_w = start_fld(pst_w, PH_HS, 16'd4);
          end
        end
        pst_w = settle(pst_w);
      end
    end else if (pst_q.phase != PH_IGNORE && pst_q.rem != 16'd0) begin
      pst_w.rec_left = pst_q.rec_left - 16'd1;
      pst_w.rem      = pst_q.rem - 16'd1;
      pst_w.fv       = {pst_q.fv[23:0], b};
      if (pst_q.phase == PH_NAME) begin
        push_name          = 1'b1;
        res_name.kind      = trsp_pkg::KindName;
        res_name.name_byte = b;
        res_name.name_last = (pst_w.rem == 16'd0);
      end
      pst_w = settle(pst_w);
    end
    cnt_w = (cnt_q == '1) ? cnt_q : cnt_q + 17'd1;

    push_sum  = in_data_i.last;
    rec_valid = pst_w.hdr_ok && ({1'b0, cnt_w} >= 18'd5 + {2'd0, hlen});
    res_sum   = '0;
    res_sum.kind = trsp_pkg::KindSummary;
    if (rec_valid) begin
      res_sum.valid_res  = 1'b1;
      res_sum.rec_kind   = hdr_w[39:32];
      res_sum.rec_ver    = hdr_w[31:16];
      res_sum.rec_len    = hlen;
      res_sum.hs_present = pst_w.has_hs;
      res_sum.hs_kind    = pst_w.hs_type;
      res_sum.ch_flag    = pst_w.is_ch;
      res_sum.truncated  = pst_w.trunc;
      res_sum.sni_found  = pst_w.sni && !pst_w.trunc;
    end

    pst_d = pst_q;
    cnt_d = cnt_q;
    hdr_d = hdr_q;
    if (in_fire) begin
      if (in_data_i.last) begin
        pst_d = PstReset;
        cnt_d = '0;
        hdr_d = '0;
      end else begin
        pst_d = pst_w;
        cnt_d = cnt_w;
        hdr_d = hdr_w;
      end
    end
  end

  assign n_push      = in_fire ? ({2'd0, push_name} + {2'd0, push_sum}) : 3'd0;
  assign in_ready_o  = cnt_fifo_q <= 3'd2;
  assign out_valid_o = cnt_fifo_q != 3'd0;
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q      <= PstReset;
      cnt_q      <= '0;
      hdr_q      <= '0;
      max_len_q  <= trsp_pkg::MaxLenReset;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_fifo_q <= '0;
    end else begin
      pst_q <= pst_d;
      cnt_q <= cnt_d;
      hdr_q <= hdr_d;
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
      wr_ptr_q   <= wr_ptr_q + n_push[1:0];
      rd_ptr_q   <= rd_ptr_q + {1'b0, out_fire};
      cnt_fifo_q <= cnt_fifo_q + n_push - {2'd0, out_fire};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (push_name) begin
        fifo_q[wr_ptr_q] <= res_name;
        if (push_sum) begin
          fifo_q[wr_ptr_q + 2'd1] <= res_sum;
        end
      end else if (push_sum) begin
        fifo_q[wr_ptr_q] <= res_sum;
      end
    end
  end

endmodule
